FILE: design/hexca_pkg.sv
`default_nettype none
package hexca_pkg;

   localparam int unsigned MAX_GRID_SIDE = 64;
   localparam int unsigned RULE_DEPTH = 16384;
   localparam int unsigned RULE_BITS  = 14;
   localparam logic [31:0] LCG_MUL    = 32'd1103515245;
   localparam logic [31:0] LCG_ADD    = 32'd12345;
   localparam logic [7:0]  GEN_LIMIT  = 8'd200;
   localparam logic [6:0]  SIDE_MIN   = 7'd4;

   localparam int unsigned CSR_INDEX_W  = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_RULE_SEED = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INIT_SEED = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GEN_COUNT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_SIDE = 3'd3;

   localparam logic FUNC_RUN  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef struct packed {
      logic       func;
      logic [5:0] row;
      logic [5:0] col;
   } req_type;

   typedef struct packed {
      logic [1:0] cell_state;
      logic [7:0] generations_done;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] seed;
   } lcg_ctl_type;

endpackage
`default_nettype wire

FILE: design/hexca_lcg.sv
`default_nettype none
// Shared generator step: one multiply-add per cycle while step is high, product registered.
module hexca_lcg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hexca_pkg::lcg_ctl_type ctl,
   input  wire logic                  step,
   output logic [1:0]                 value
);
   logic [31:0] state_ff, state_in;
   logic [31:0] nxt;

   assign nxt = state_ff * hexca_pkg::LCG_MUL + hexca_pkg::LCG_ADD;

   always_comb begin
      state_in = state_ff;
      if (ctl.start) begin
         state_in = ctl.seed | 32'd1;
      end else if (step) begin
         state_in = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // value is bits 17:16 of the next state
   assign value = nxt[17:16];
endmodule
`default_nettype wire

FILE: design/hex_cellular_automaton_engine_core.sv
`default_nettype none
// Channel  Direction  Payload                        Handshake
// req      in         func, row, col (req_type)      req_valid / req_stall
// rsp      out        cell_state, generations_done   rsp_valid / rsp_stall
// csr      in         csr_index, csr_wdata           csr_write, no wait
//
// A read passes through ST_READA and ST_READW before rsp_valid rises.
// A run raises rsp_valid after these steps: rule fill one entry a cycle from the
// shared generator, one reseed step, grid fill one cell a cycle, then per
// generation and cell seven grid reads and one rule read, and a copy pass
// that reads then writes each cell (ST_COPYR, ST_COPYW).
// Reset is synchronous; no clearing pass, stores are undefined until a run.
// req_stall is high from acceptance until the result transfer completes.
module hex_cellular_automaton_engine_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire hexca_pkg::req_type    req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output hexca_pkg::rsp_type         rsp_data,
   input  wire logic                  csr_write,
   input  wire logic [hexca_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]           csr_wdata
);
   localparam int unsigned CW    = $clog2(hexca_pkg::MAX_GRID_SIDE);
   localparam int unsigned AW    = 2 * CW;
   localparam int unsigned DEPTH = hexca_pkg::MAX_GRID_SIDE * hexca_pkg::MAX_GRID_SIDE;
   localparam int unsigned SW    = $clog2(hexca_pkg::MAX_GRID_SIDE + 1);
   localparam int unsigned RULE_BITS_W = hexca_pkg::RULE_BITS;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RULE  = 4'd1;
   localparam logic [3:0] ST_GRID  = 4'd2;
   localparam logic [3:0] ST_NADDR = 4'd3;
   localparam logic [3:0] ST_NWAIT = 4'd4;
   localparam logic [3:0] ST_RADDR = 4'd5;
   localparam logic [3:0] ST_RWAIT = 4'd6;
   localparam logic [3:0] ST_COPYR = 4'd7;
   localparam logic [3:0] ST_COPYW = 4'd8;
   localparam logic [3:0] ST_READA = 4'd9;
   localparam logic [3:0] ST_READW = 4'd10;
   localparam logic [3:0] ST_RESP  = 4'd11;
   localparam logic [3:0] ST_GSEED = 4'd12;

   // configuration registers
   logic [31:0] rule_seed_ff, init_seed_ff;
   logic [7:0]  gen_count_ff;
   logic [6:0]  grid_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_seed_ff <= 32'd66;
         init_seed_ff <= 32'd7;
         gen_count_ff <= 8'd16;
         grid_side_ff <= 7'd28;
      end else if (csr_write) begin
         unique case (csr_index)
            hexca_pkg::REG_RULE_SEED: rule_seed_ff <= csr_wdata;
            hexca_pkg::REG_INIT_SEED: init_seed_ff <= csr_wdata;
            hexca_pkg::REG_GEN_COUNT: gen_count_ff <= csr_wdata[7:0];
            hexca_pkg::REG_GRID_SIDE: grid_side_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // saturated side and generation count
   logic [SW-1:0] side;
   logic [7:0]    gens;
   always_comb begin
      if ({25'd0, grid_side_ff} > hexca_pkg::MAX_GRID_SIDE) begin
         side = SW'(hexca_pkg::MAX_GRID_SIDE);
      end else if (grid_side_ff < hexca_pkg::SIDE_MIN) begin
         side = SW'(hexca_pkg::SIDE_MIN);
      end else begin
         side = SW'(grid_side_ff);
      end
      gens = (gen_count_ff > hexca_pkg::GEN_LIMIT) ? hexca_pkg::GEN_LIMIT : gen_count_ff;
   end

   logic [3:0]          state_ff, state_in;

   logic [RULE_BITS_W-1:0] rcnt_ff, rcnt_in;
   logic [CW-1:0]  r_ff, r_in, c_ff, c_in;
   logic [2:0]     k_ff, k_in;
   logic [13:0]    idx_ff, idx_in;
   logic [7:0]     gdone_ff, gdone_in;
   hexca_pkg::rsp_type rsp_ff, rsp_in;
   hexca_pkg::req_type req_ff, req_in;

   // generator
   hexca_pkg::lcg_ctl_type lcg_ctl;
   logic lcg_step;
   logic [1:0] lcg_value;
   hexca_lcg u_lcg (.clock, .reset, .ctl(lcg_ctl), .step(lcg_step), .value(lcg_value));

   // memories
   logic [1:0] rule_mem [hexca_pkg::RULE_DEPTH];
   logic [1:0] grid_mem [DEPTH];
   logic [1:0] next_mem [DEPTH];
   logic rule_we, grid_we, next_we;
   logic [13:0] rule_waddr, rule_raddr;
   logic [1:0]  rule_wdata, rule_rd_ff;
   logic [AW-1:0] grid_waddr, grid_raddr, next_addr;
   logic [1:0]  grid_wdata, grid_rd_ff, next_rd_ff;

   always_ff @(posedge clock) begin
      if (rule_we) rule_mem[rule_waddr] <= rule_wdata;
      rule_rd_ff <= rule_mem[rule_raddr];
   end
   always_ff @(posedge clock) begin
      if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
      grid_rd_ff <= grid_mem[grid_raddr];
   end
   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_addr] <= rule_rd_ff;
      next_rd_ff <= next_mem[next_addr];
   end

   // neighbour address for step k (k = 6 means the cell itself)
   logic [CW:0] nr, nc;
   logic signed [2:0] dr, dc;
   always_comb begin
      dr = 3'sd0;
      dc = 3'sd0;
      case (k_ff)
         3'd0: begin dr = -3'sd1; dc = r_ff[0] ? 3'sd0 : -3'sd1; end
         3'd1: begin dr = -3'sd1; dc = r_ff[0] ? 3'sd1 : 3'sd0; end
         3'd2: begin dr = 3'sd0;  dc = -3'sd1; end
         3'd3: begin dr = 3'sd0;  dc = 3'sd1; end
         3'd4: begin dr = 3'sd1;  dc = r_ff[0] ? 3'sd0 : -3'sd1; end
         3'd5: begin dr = 3'sd1;  dc = r_ff[0] ? 3'sd1 : 3'sd0; end
         default: begin dr = 3'sd0; dc = 3'sd0; end
      endcase
      nr = {1'b0, r_ff} + {{(CW-1){dr[2]}}, dr[1:0]};
      nc = {1'b0, c_ff} + {{(CW-1){dc[2]}}, dc[1:0]};
      // wrap per axis: -1 shows as all ones in CW+1 bits
      if (r_ff == '0 && dr[2]) nr = (CW+1)'(side - 1);
      else if (nr == (CW+1)'(side)) nr = '0;
      if (c_ff == '0 && dc[2]) nc = (CW+1)'(side - 1);
      else if (nc == (CW+1)'(side)) nc = '0;
   end

   logic last_c, last_r;
   assign last_c = ({1'b0, c_ff} == (CW+1)'(side - 1));
   assign last_r = ({1'b0, r_ff} == (CW+1)'(side - 1));

   always_comb begin
      state_in = state_ff;
      rcnt_in  = rcnt_ff;
      r_in = r_ff; c_in = c_ff; k_in = k_ff;
      idx_in = idx_ff; gdone_in = gdone_ff;
      rsp_in = rsp_ff; req_in = req_ff;
      lcg_ctl = '0; lcg_step = 1'b0;
      rule_we = 1'b0; rule_waddr = rcnt_ff; rule_wdata = lcg_value;
      rule_raddr = idx_ff;
      grid_we = 1'b0; grid_waddr = {r_ff, c_ff}; grid_wdata = lcg_value;
      grid_raddr = {nr[CW-1:0], nc[CW-1:0]};
      next_we = 1'b0; next_addr = {r_ff, c_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (req_data.func == hexca_pkg::FUNC_RUN) begin
                  lcg_ctl.start = 1'b1;
                  lcg_ctl.seed  = rule_seed_ff;
                  rcnt_in = '0;
                  state_in = ST_RULE;
               end else begin
                  state_in = ST_READA;
               end
            end
         end
         ST_RULE: begin
            rule_we = 1'b1; lcg_step = 1'b1;
            rcnt_in = rcnt_ff + 1'b1;
            if (&rcnt_ff) state_in = ST_GSEED;
         end
         ST_GSEED: begin
            lcg_ctl.start = 1'b1; lcg_ctl.seed = init_seed_ff;
            r_in = '0; c_in = '0;
            state_in = ST_GRID;
         end
         ST_GRID: begin
            grid_we = 1'b1; lcg_step = 1'b1;
            c_in = c_ff + 1'b1;
            if (last_c) begin
               c_in = '0; r_in = r_ff + 1'b1;
               if (last_r) begin
                  r_in = '0; gdone_in = '0; k_in = 3'd6;
                  state_in = (gens == 8'd0) ? ST_RESP : ST_NADDR;
                  rsp_in.cell_state = 2'd0;
                  rsp_in.generations_done = gens;
               end
            end
         end
         ST_NADDR: begin
            state_in = ST_NWAIT;
         end
         ST_NWAIT: begin
            // shift in one 2-bit state: self first, then neighbors 0..5
            idx_in = {grid_rd_ff, idx_ff[13:2]};
            if (k_ff == 3'd5) begin
               state_in = ST_RADDR;
            end else begin
               k_in = (k_ff == 3'd6) ? 3'd0 : k_ff + 1'b1;
               state_in = ST_NADDR;
            end
         end
         ST_RADDR: state_in = ST_RWAIT;
         ST_RWAIT: begin
            next_we = 1'b1;
            k_in = 3'd6;
            c_in = c_ff + 1'b1;
            state_in = ST_NADDR;
            if (last_c) begin
               c_in = '0; r_in = r_ff + 1'b1;
               if (last_r) begin
                  r_in = '0; state_in = ST_COPYR;
               end
            end
         end
         ST_COPYR: state_in = ST_COPYW;
         ST_COPYW: begin
            grid_we = 1'b1; grid_wdata = next_rd_ff;
            c_in = c_ff + 1'b1;
            state_in = ST_COPYR;
            if (last_c) begin
               c_in = '0; r_in = r_ff + 1'b1;
               if (last_r) begin
                  r_in = '0;
                  gdone_in = gdone_ff + 1'b1;
                  state_in = (gdone_ff + 8'd1 == gens) ? ST_RESP : ST_NADDR;
               end
            end
         end
         ST_READA: begin
            grid_raddr = {req_ff.row[CW-1:0], req_ff.col[CW-1:0]};
            state_in = ST_READW;
         end
         ST_READW: begin
            rsp_in.generations_done = 8'd0;
            rsp_in.cell_state = ({1'b0, req_ff.row} < 7'(side) &&
                                 {1'b0, req_ff.col} < 7'(side)) ? grid_rd_ff : 2'd0;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rcnt_ff <= rcnt_in; r_ff <= r_in; c_ff <= c_in; k_ff <= k_in;
      idx_ff <= idx_in; gdone_ff <= gdone_in; rsp_ff <= rsp_in; req_ff <= req_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

FILE: design/hexca_checker.sv
`default_nettype none
module hexca_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire hexca_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken with result pending");
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("ready right after transfer");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cell_state == 2'd0 || rsp_data.generations_done == 8'd0)
      else $error("both result fields nonzero");
endmodule

bind hex_cellular_automaton_engine_core hexca_checker u_hexca_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);
`default_nettype wire
